/* rtl/pttd_pkg.sv */
// Package with the shared types and constants of the PWM tick telemetry decoder.
`default_nettype none

package pttd_pkg;

    localparam int DATA_W          = 16;
    localparam int SLOT_W          = 5;
    localparam int KIND_W          = 3;
    localparam int FRAME_COUNT_DEF = 12;
    localparam int PULSE_SHIFT     = 4;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 40;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [DATA_W-1:0] OE_TIME_RESET = 16'hFFFF;

    // Register index bit of paddr for the output enable time register.
    localparam logic REG_OUTPUT_ENABLE = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYNC     = 3'd0,
        KIND_STORED   = 3'd1,
        KIND_SPURIOUS = 3'd2,
        KIND_UNSYNCED = 3'd3,
        KIND_RECORD   = 3'd4
    } kind_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic load_pend;
        logic load_rec;
    } dp_cmd_t;

    typedef struct packed {
        logic pulse_end;
        logic complete;
        logic out_free;
        logic rec_last;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/pttd_ctrl.sv */
// Controller state machine that sequences request capture, evaluation and result output.
`default_nettype none

module pttd_ctrl
    import pttd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_REC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (stat.pulse_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.complete)
                begin
                    state_next = ST_REC;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_pend = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REC:
            begin
                if (stat.out_free)
                begin
                    cmd.load_rec = 1'b1;
                    if (stat.rec_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pttd_dp.sv */
// Datapath with the decoder state, the record store and the output register.
`default_nettype none

module pttd_dp
    import pttd_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DATA_W-1:0] timing_compare,
    input  wire logic [DATA_W-1:0] channel_value,
    input  wire logic [DATA_W-1:0] output_enable_time,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [KIND_W-1:0]      out_kind,
    output logic [SLOT_W-1:0]      out_slot,
    output logic [DATA_W-1:0]      out_value,
    output logic [DATA_W-1:0]      out_generation,
    output logic                   out_last
);

    localparam int DEPTH = FRAME_COUNT - 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] tc_reg;
    logic [DATA_W-1:0] cv_reg;
    logic [DATA_W-1:0] pulse_end_reg;
    logic [DATA_W-1:0] pulse_end_next;
    logic [SLOT_W-1:0] frame_slot_reg;
    logic [SLOT_W-1:0] frame_slot_next;
    logic [DATA_W-1:0] record_count_reg;
    logic [DATA_W-1:0] record_count_next;
    logic [IDX_W-1:0]  rec_idx_reg;
    logic [IDX_W-1:0]  rec_idx_next;
    kind_t             pend_kind_reg;
    kind_t             pend_kind_next;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [SLOT_W-1:0] pend_slot_next;
    logic [DATA_W-1:0] pend_value_reg;
    logic [DATA_W-1:0] pend_value_next;
    logic [DATA_W-1:0] record_store [DEPTH];

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_gen_reg;
    logic              out_last_reg;

    logic [DATA_W-1:0] offset;
    logic              is_pulse_end;
    logic              is_sync;
    logic              is_spurious;
    logic              is_complete;
    logic              store_write;
    logic [IDX_W-1:0]  store_addr;

    assign offset       = cv_reg - pulse_end_reg;
    assign is_pulse_end = tc_reg < output_enable_time;
    assign is_sync      = cv_reg <= pulse_end_reg;
    assign is_spurious  = offset <= (pulse_end_reg >> PULSE_SHIFT);
    assign is_complete  = !is_pulse_end && !is_sync && (frame_slot_reg != '0)
                          && !is_spurious
                          && (frame_slot_reg == SLOT_W'(FRAME_COUNT - 1));
    assign store_addr   = IDX_W'(frame_slot_reg - SLOT_W'(1));
    assign store_write  = cmd.eval && !is_pulse_end && !is_sync && (frame_slot_reg != '0);

    always_comb
    begin
        stat.pulse_end = is_pulse_end;
        stat.complete  = is_complete;
        stat.out_free  = !out_valid_reg || out_ready;
        stat.rec_last  = rec_idx_reg == IDX_W'(DEPTH - 1);
    end

    always_comb
    begin
        pulse_end_next    = pulse_end_reg;
        frame_slot_next   = frame_slot_reg;
        record_count_next = record_count_reg;
        pend_kind_next    = pend_kind_reg;
        pend_slot_next    = pend_slot_reg;
        pend_value_next   = pend_value_reg;
        rec_idx_next      = rec_idx_reg;
        if (cmd.eval)
        begin
            rec_idx_next = '0;
            priority if (is_pulse_end)
            begin
                pulse_end_next = cv_reg;
            end
            else if (is_sync)
            begin
                frame_slot_next = SLOT_W'(1);
                pend_kind_next  = KIND_SYNC;
                pend_slot_next  = SLOT_W'(1);
                pend_value_next = '0;
            end
            else if (frame_slot_reg == '0)
            begin
                pend_kind_next  = KIND_UNSYNCED;
                pend_slot_next  = '0;
                pend_value_next = offset;
            end
            else if (is_spurious)
            begin
                frame_slot_next = '0;
                pend_kind_next  = KIND_SPURIOUS;
                pend_slot_next  = frame_slot_reg;
                pend_value_next = offset;
            end
            else if (is_complete)
            begin
                frame_slot_next   = '0;
                record_count_next = record_count_reg + DATA_W'(1);
            end
            else
            begin
                frame_slot_next = frame_slot_reg + SLOT_W'(1);
                pend_kind_next  = KIND_STORED;
                pend_slot_next  = frame_slot_reg;
                pend_value_next = offset;
            end
        end
        else if (cmd.load_rec)
        begin
            rec_idx_next = rec_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_end_reg    <= '0;
            frame_slot_reg   <= '0;
            record_count_reg <= '0;
            rec_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pulse_end_reg    <= pulse_end_next;
            frame_slot_reg   <= frame_slot_next;
            record_count_reg <= record_count_next;
            rec_idx_reg      <= rec_idx_next;
            if (cmd.load_pend || cmd.load_rec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg  <= pend_kind_next;
        pend_slot_reg  <= pend_slot_next;
        pend_value_reg <= pend_value_next;
        if (cmd.capture)
        begin
            tc_reg <= timing_compare;
            cv_reg <= channel_value;
        end
        if (store_write)
        begin
            record_store[store_addr] <= offset;
        end
        if (cmd.load_pend)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_slot_reg  <= pend_slot_reg;
            out_value_reg <= pend_value_reg;
            out_gen_reg   <= record_count_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.load_rec)
        begin
            out_kind_reg  <= KIND_RECORD;
            out_slot_reg  <= SLOT_W'(rec_idx_reg) + SLOT_W'(1);
            out_value_reg <= record_store[rec_idx_reg];
            out_gen_reg   <= record_count_reg;
            out_last_reg  <= stat.rec_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_slot       = out_slot_reg;
    assign out_value      = out_value_reg;
    assign out_generation = out_gen_reg;
    assign out_last       = out_last_reg;

endmodule

`default_nettype wire

/* rtl/pwm_tick_telemetry_decoder.sv */
// Top level of the PWM tick telemetry decoder with the stream ports and the APB register.
// A request is taken in one cycle and evaluated in the next; a single result is then loaded
// into the output register in the EMIT state once the output register is free.
// A pulse-end request passes through IDLE and EVAL only, a single-result request also through
// EMIT, and a completed record through REC, one record word per cycle from the store;
// a stalled output holds the controller until the output register frees up.
// Reset clears the control state, the pulse-end value, slot and generation; the
// record store is not cleared and is always written before it is read.
`default_nettype none

module pwm_tick_telemetry_decoder
    import pttd_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // timing_compare[15:0], channel_value[31:16]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // slot[4:0], value[20:5], generation[36:21], zero padding[39:37]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // kind[2:0]
    output logic [KIND_W-1:0]           m_tuser,
    output logic                        m_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [DATA_W-1:0] oe_time_reg;
    logic [SLOT_W-1:0] out_slot;
    logic [DATA_W-1:0] out_value;
    logic [DATA_W-1:0] out_generation;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oe_time_reg <= OE_TIME_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUTPUT_ENABLE))
        begin
            oe_time_reg <= pwdata[DATA_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_OUTPUT_ENABLE)
        begin
            prdata = APB_DATA_W'(oe_time_reg);
        end
    end

    pttd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pttd_dp #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .timing_compare     (s_tdata[DATA_W-1:0]),
        .channel_value      (s_tdata[2*DATA_W-1:DATA_W]),
        .output_enable_time (oe_time_reg),
        .cmd                (cmd),
        .stat               (stat),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .out_kind           (m_tuser),
        .out_slot           (out_slot),
        .out_value          (out_value),
        .out_generation     (out_generation),
        .out_last           (m_tlast)
    );

    assign m_tdata = {3'b000, out_generation, out_value, out_slot};

    property p_last_is_record;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_RECORD);
    endproperty
    a_last_is_record: assert property (p_last_is_record)
        else $error("last flag on a result that is not a record word");

    property p_sync_fields;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_SYNC)) |->
            ((m_tdata[4:0] == 5'd1) && (m_tdata[20:5] == 16'd0));
    endproperty
    a_sync_fields: assert property (p_sync_fields)
        else $error("sync result with wrong slot or value");

    property p_record_slot;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_RECORD)) |->
            ((m_tdata[4:0] != 5'd0) && (m_tdata[4:0] < 5'(FRAME_COUNT)));
    endproperty
    a_record_slot: assert property (p_record_slot)
        else $error("record word slot out of range");

    property p_one_request_at_a_time;
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_one_request_at_a_time: assert property (p_one_request_at_a_time)
        else $error("new request taken while one is in work");

endmodule

`default_nettype wire

/* tb/sv/tick_decode_checker.sv */
// Checker that watches the decoder's channels, predicts its results and compares them.
`timescale 1ns / 1ps

module tick_decode_checker
    import pttd_pkg::*;
#(
    parameter int                    FRAME_COUNT = FRAME_COUNT_DEF,
    parameter logic [APB_ADDR_W-1:0] OE_ADDR     = '0
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [KIND_W-1:0]     m_tuser,
    input  wire logic                  m_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    output int                         mismatches,
    output int                         pending
);

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] generation;
        logic              last;
    } telem_word_t;

    telem_word_t       expected_words[$];
    telem_word_t       want;
    telem_word_t       got;
    logic [DATA_W-1:0] oe_time;
    logic [DATA_W-1:0] pulse_end;
    logic [DATA_W-1:0] gen_count;
    logic [SLOT_W-1:0] frame_slot;
    logic [DATA_W-1:0] record_words [1:FRAME_COUNT-1];
    int                errors;

    function automatic void queue_word(kind_t k, int s, logic [DATA_W-1:0] v,
                                       logic [DATA_W-1:0] g, logic l);
        telem_word_t w;
        w.kind       = k;
        w.slot       = SLOT_W'(s);
        w.value      = v;
        w.generation = g;
        w.last       = l;
        expected_words.push_back(w);
    endfunction

    // Works out the results that one timer event causes and updates the decoder state.
    function automatic void decode_tick(logic [DATA_W-1:0] tc, logic [DATA_W-1:0] cv);
        logic [DATA_W-1:0] offset;
        logic [SLOT_W-1:0] cur;
        if (tc < oe_time)
        begin
            pulse_end = cv;
            return;
        end
        if (cv <= pulse_end)
        begin
            frame_slot = 1;
            queue_word(KIND_SYNC, 1, '0, gen_count, 1'b0);
            return;
        end
        offset = cv - pulse_end;
        cur    = frame_slot;
        if (cur == 0)
        begin
            queue_word(KIND_UNSYNCED, 0, offset, gen_count, 1'b0);
            return;
        end
        record_words[cur] = offset;
        if (offset <= (pulse_end >> PULSE_SHIFT))
        begin
            frame_slot = 0;
            queue_word(KIND_SPURIOUS, cur, offset, gen_count, 1'b0);
            return;
        end
        if (int'(cur) + 1 >= FRAME_COUNT)
        begin
            frame_slot = 0;
            gen_count  = gen_count + 1'b1;
            for (int i = 1; i < FRAME_COUNT; i++)
            begin
                queue_word(KIND_RECORD, i, record_words[i], gen_count, i == FRAME_COUNT - 1);
            end
            return;
        end
        frame_slot = cur + 1'b1;
        queue_word(KIND_STORED, cur, offset, gen_count, 1'b0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            oe_time    = OE_TIME_RESET;
            pulse_end  = '0;
            gen_count  = '0;
            frame_slot = '0;
            errors     = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == OE_ADDR)
            begin
                oe_time = pwdata[DATA_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                got.kind       = kind_t'(m_tuser);
                got.slot       = m_tdata[SLOT_W-1:0];
                got.value      = m_tdata[SLOT_W +: DATA_W];
                got.generation = m_tdata[SLOT_W + DATA_W +: DATA_W];
                got.last       = m_tlast;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result: kind %0d slot %0d value %h gen %0d last %0b",
                                 got.kind, got.slot, got.value, got.generation, got.last);
                    end
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: expected kind %0d slot %0d value %h gen %0d last %0b",
                                     want.kind, want.slot, want.value, want.generation, want.last);
                            $display("          actual   kind %0d slot %0d value %h gen %0d last %0b",
                                     got.kind, got.slot, got.value, got.generation, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_tick(s_tdata[DATA_W-1:0], s_tdata[DATA_W +: DATA_W]);
            end
            mismatches <= errors;
            pending    <= expected_words.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the decoder testbench: clock, reset, stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module testbench;
    import pttd_pkg::*;

    localparam int                    FRAME_COUNT  = FRAME_COUNT_DEF;
    localparam logic [APB_ADDR_W-1:0] OE_ADDR      = {REG_OUTPUT_ENABLE, 2'b00};
    localparam int                    DRAIN_CYCLES = 2 * FRAME_COUNT + 10;
    localparam int                    LIMIT        = 600000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     mismatches;
    int                     pending;
    int                     sent        = 0;
    int                     hold_left   = 0;
    int                     cycle_count = 0;
    bit                     steady      = 1'b0;
    logic [DATA_W-1:0]      cur_oe      = OE_TIME_RESET;
    logic [DATA_W-1:0]      cur_pe      = '0;

    pwm_tick_telemetry_decoder #(.FRAME_COUNT(FRAME_COUNT)) DUT (.*);

    tick_decode_checker #(.FRAME_COUNT(FRAME_COUNT), .OE_ADDR(OE_ADDR)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_pause();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 2) == 0)
            begin
                hold_left <= pick_pause();
            end
        end
    end

    // Valid stays high between back-to-back requests and only drops for a gap.
    task automatic send_tick(input logic [DATA_W-1:0] tc, input logic [DATA_W-1:0] cv);
        int gap;
        gap = pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cv, tc};
        do
            @(posedge clk);
        while (!s_tready);
        if (tc < cur_oe)
        begin
            cur_pe = cv;
        end
        sent++;
    endtask

    task automatic pulse_end_tick(input logic [DATA_W-1:0] pe);
        send_tick($urandom_range(0, cur_oe - 1), pe);
    endtask

    task automatic capture_tick(input logic [DATA_W-1:0] cv);
        send_tick($urandom_range(cur_oe, 16'hFFFF), cv);
    endtask

    // One sync followed by a run of words, usually a full record.
    task automatic send_frame();
        logic [DATA_W-1:0] pe;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        int                words;
        int                k;
        if (cur_oe == 0)
        begin
            pe = cur_pe;
        end
        else
        begin
            pe = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hEFFF)
                                             : $urandom_range(0, 16'h0FFF);
            pulse_end_tick(pe);
        end
        lo = (pe >> PULSE_SHIFT) + 1'b1;
        hi = 16'hFFFF - pe;
        capture_tick(pe - $urandom_range(0, (pe < 64) ? pe : 64));
        words = ($urandom_range(0, 3) == 0) ? $urandom_range(1, FRAME_COUNT - 1)
                                            : FRAME_COUNT - 1;
        for (k = 0; k < words; k++)
        begin
            if (cur_oe != 0 && $urandom_range(0, 2) != 0)
            begin
                pulse_end_tick(pe);
            end
            if (hi < lo || $urandom_range(0, 29) == 0)
            begin
                capture_tick(pe + $urandom_range(0, pe >> PULSE_SHIFT));
            end
            else
            begin
                capture_tick(pe + $urandom_range(lo, hi));
            end
        end
    endtask

    task automatic write_oe_time(input logic [DATA_W-1:0] t);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OE_ADDR;
        pwdata  <= {{(APB_DATA_W - DATA_W){1'b0}}, t};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_oe = t;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] oe, input int quota);
        int start;
        write_oe_time(oe);
        start = sent;
        while (sent - start < quota)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4)) send_tick($urandom, $urandom);
            end
            else
            begin
                send_frame();
            end
        end
        // Leave a moderate pulse end behind for the next setting.
        if (cur_oe != 0)
        begin
            pulse_end_tick($urandom_range(0, 16'h0FFF));
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        int s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(16'hFFFF, 16'hFFFF);
        send_tick(16'hFFFF, 16'h0000);
        send_tick(16'h0000, 16'h0100);
        send_tick(16'hFFFF, 16'h0100);
        for (s = 1; s < FRAME_COUNT; s++)
        begin
            if (s == 1)
            begin
                send_tick(16'hFFFF, 16'h0111);
            end
            else if (s == FRAME_COUNT - 1)
            begin
                send_tick(16'hFFFF, 16'hFFFF);
            end
            else
            begin
                send_tick(16'hFFFF, 16'h0100 + $urandom_range(16'h0011, 16'hFEFF));
            end
        end
        send_tick(16'hFFFF, 16'h0050);
        send_tick(16'hFFFF, 16'h0110);
        send_tick(16'hFFFF, 16'h0101);
        send_tick(16'hFFFE, 16'h0000);
        send_tick(16'hFFFF, 16'h0000);
        send_tick(16'hFFFF, 16'h0001);
        wait_drained();

        run_phase(16'h8000, 45);
        run_phase(16'h0000, 45);
        run_phase($urandom_range(1, 16'hFFFE), 45);
        run_phase(16'hFFFF, 45);

        if (mismatches == 0)
        begin
            $display("pwm_tick_telemetry_decoder test passed");
        end
        else
        begin
            $display("pwm_tick_telemetry_decoder test failed");
        end
        $finish;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pwm_tick_telemetry_decoder test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/pttd_pkg.sv
rtl/pttd_ctrl.sv
rtl/pttd_dp.sv
rtl/pwm_tick_telemetry_decoder.sv
tb/sv/tick_decode_checker.sv
tb/sv/testbench.sv
